### hdl/qtba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qtba_pkg;

    localparam int ATLAS_WIDTH_DEF  = 4096;
    localparam int ATLAS_HEIGHT_DEF = 4096;
    localparam int MAX_TILE_DEF     = 2048;
    localparam int MIN_TILE_DEF     = 128;
    localparam int LIGHT_SLOTS_DEF  = 64;

    typedef struct packed {
        logic [5:0]  light_id;
        logic [63:0] light_hash;
        logic [63:0] geometry_hash;
        logic [3:0]  size_log2;
    } qtba_in_t;

    typedef struct packed {
        logic [11:0] tile_x;
        logic [11:0] tile_y;
        logic [3:0]  tile_log2;
        logic [1:0]  render_mode;
        logic        alloc_failed;
    } qtba_out_t;

    typedef enum logic [1:0] {
        MODE_RENDER = 2'd0,
        MODE_STATIC = 2'd1,
        MODE_CACHED = 2'd2
    } qtba_mode_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_SLOT_RD,
        ST_SLOT_CHK,
        ST_F_START,
        ST_F_SCAN,
        ST_F_DEC,
        ST_F_DN,
        ST_F_UP,
        ST_F_PUT,
        ST_A_FIND,
        ST_A_POP,
        ST_A_POPW,
        ST_A_SPLIT,
        ST_A_LAST,
        ST_A_LASTW,
        ST_FIN
    } qtba_state_t;

endpackage

`default_nettype wire

### hdl/qtba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module qtba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wa,
    input  wire logic [WIDTH-1:0] wd,
    input  wire logic [AW-1:0]    ra,
    output logic      [WIDTH-1:0] rq
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rq <= mem[ra];
    end

endmodule

`default_nettype wire

### hdl/atlas_quadtree_buddy_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: a request reads its light's slot; a bad slot id or a same-size hit goes straight to the
// result, while a fresh allocation searches coarser levels for a free node and splits it down
// level by level. A free pushes the tile onto an empty or top list, or scans its list and
// merges it with three waiting siblings or inserts it in parent order. One beat at a time: ready
// again the cycle after the result is loaded (which waits while the output is full and m_ready low).
// Reset (aresetn low, synchronous): an init sweep clears the slot table and loads the top tiles.
module atlas_quadtree_buddy_allocator
    import qtba_pkg::*;
#(
    parameter int ATLAS_WIDTH  = ATLAS_WIDTH_DEF,
    parameter int ATLAS_HEIGHT = ATLAS_HEIGHT_DEF,
    parameter int MAX_TILE     = MAX_TILE_DEF,
    parameter int MIN_TILE     = MIN_TILE_DEF,
    parameter int LIGHT_SLOTS  = LIGHT_SLOTS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire qtba_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output qtba_out_t      m_data
);

    // geometry, everything kept in MIN_TILE units
    localparam int LOG2_MAX   = $clog2(MAX_TILE);
    localparam int LOG2_MIN   = $clog2(MIN_TILE);
    localparam int NUM_LEVELS = LOG2_MAX - LOG2_MIN + 1;
    localparam int LW         = $clog2(NUM_LEVELS);
    localparam int XW         = $clog2(ATLAS_WIDTH / MIN_TILE);
    localparam int YW         = $clog2(ATLAS_HEIGHT / MIN_TILE);
    localparam int LEVEL_CAP  = (ATLAS_WIDTH / MIN_TILE) * (ATLAS_HEIGHT / MIN_TILE);
    localparam int IDXW       = $clog2(LEVEL_CAP);
    localparam int CW         = IDXW + 1;
    localparam int NX0        = ATLAS_WIDTH / MAX_TILE;
    localparam int NY0        = ATLAS_HEIGHT / MAX_TILE;
    localparam int N0         = NX0 * NY0;
    localparam int NX0_LOG2   = $clog2(NX0);
    localparam int TOP_U_LOG2 = LOG2_MAX - LOG2_MIN;
    localparam int NW         = XW + YW;
    localparam int FM_DEPTH   = NUM_LEVELS * LEVEL_CAP;
    localparam int FM_AW      = LW + IDXW;
    localparam int SAW        = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
    localparam int SMW        = 1 + LW + NW + 128;
    localparam int INIT_N     = (LIGHT_SLOTS > N0) ? LIGHT_SLOTS : N0;
    localparam int INW        = $clog2(INIT_N + 1);

    // slot word layout: {valid, level, y, x, light_hash, geometry_hash}
    localparam int SM_GH = 0;
    localparam int SM_LH = 64;
    localparam int SM_X  = 128;
    localparam int SM_Y  = SM_X + XW;
    localparam int SM_L  = SM_Y + YW;
    localparam int SM_V  = SM_L + LW;

    qtba_state_t    state_reg, state_next;
    logic [CW-1:0]  cnt_reg  [NUM_LEVELS];
    logic [CW-1:0]  cnt_next [NUM_LEVELS];
    qtba_in_t       in_reg, in_next;
    logic [LW-1:0]  req_lvl_reg, req_lvl_next;
    logic [3:0]     s_sat_reg, s_sat_next;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [XW-1:0]  tx_reg, tx_next, nx_reg, nx_next;
    logic [YW-1:0]  ty_reg, ty_next, ny_reg, ny_next;
    logic [CW-1:0]  j_reg, j_next, ins_reg, ins_next;
    logic           pend_reg, pend_next;
    logic [1:0]     same_reg, same_next;
    logic [1:0]     child_reg, child_next;
    logic [INW-1:0] init_reg, init_next;
    qtba_out_t      res_reg, res_next;
    logic           m_valid_reg, m_valid_next;
    qtba_out_t      m_data_reg, m_data_next;

    // memory ports
    logic             fm_we;
    logic [FM_AW-1:0] fm_wa, fm_ra;
    logic [NW-1:0]    fm_wd, fm_q;
    logic             sm_we;
    logic [SAW-1:0]   sm_wa, sm_ra;
    logic [SMW-1:0]   sm_wd, sm_q;

    qtba_ram #(.WIDTH(NW), .DEPTH(FM_DEPTH), .AW(FM_AW)) u_free_ram (
        .aclk (aclk),
        .we   (fm_we),
        .wa   (fm_wa),
        .wd   (fm_wd),
        .ra   (fm_ra),
        .rq   (fm_q)
    );

    qtba_ram #(.WIDTH(SMW), .DEPTH(LIGHT_SLOTS), .AW(SAW)) u_slot_ram (
        .aclk (aclk),
        .we   (sm_we),
        .wa   (sm_wa),
        .wd   (sm_wd),
        .ra   (sm_ra),
        .rq   (sm_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            init_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                cnt_reg[i] <= (i == 0) ? CW'(N0) : '0;
            end
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg      <= in_next;
        req_lvl_reg <= req_lvl_next;
        s_sat_reg   <= s_sat_next;
        cur_reg     <= cur_next;
        tx_reg      <= tx_next;
        ty_reg      <= ty_next;
        nx_reg      <= nx_next;
        ny_reg      <= ny_next;
        j_reg       <= j_next;
        ins_reg     <= ins_next;
        pend_reg    <= pend_next;
        same_reg    <= same_next;
        child_reg   <= child_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // slot fields from the registered slot read
    logic           sv;
    logic [LW-1:0]  sl;
    logic [XW-1:0]  sx;
    logic [YW-1:0]  sy;
    logic [63:0]    slh, sgh;
    logic [31:0]    id32;
    logic [XW-1:0]  qx;
    logic [YW-1:0]  qy;

    assign sv   = sm_q[SM_V];
    assign sl   = sm_q[SM_L +: LW];
    assign sx   = sm_q[SM_X +: XW];
    assign sy   = sm_q[SM_Y +: YW];
    assign slh  = sm_q[SM_LH +: 64];
    assign sgh  = sm_q[SM_GH +: 64];
    assign id32 = 32'(in_reg.light_id);
    assign qx   = fm_q[XW-1:0];
    assign qy   = fm_q[NW-1:XW];

    // parent keys at the current level: row-major order of parent == {py, px} order
    logic [LW:0]    su;
    logic [NW-1:0]  key_q, key_t;
    logic [CW-1:0]  c_cur;
    logic [LW-1:0]  lvl_up;
    logic [XW-1:0]  h_u;
    logic [3:0]     s_in;
    logic [31:0]    init32;

    assign su     = (LW + 1)'(NUM_LEVELS) - {1'b0, cur_reg};
    assign key_q  = {qy >> su, qx >> su};
    assign key_t  = {ty_reg >> su, tx_reg >> su};
    assign c_cur  = cnt_reg[cur_reg];
    assign lvl_up = cur_reg + LW'(1);
    assign h_u    = XW'(1) << ((LW + 1)'(NUM_LEVELS - 2) - {1'b0, cur_reg});
    assign init32 = 32'(init_reg);

    always_comb begin
        s_in = s_data.size_log2;
        if (s_in < 4'(LOG2_MIN)) begin
            s_in = 4'(LOG2_MIN);
        end
        if (s_in > 4'(LOG2_MAX)) begin
            s_in = 4'(LOG2_MAX);
        end
    end

    always_comb begin
        state_next   = state_reg;
        in_next      = in_reg;
        req_lvl_next = req_lvl_reg;
        s_sat_next   = s_sat_reg;
        cur_next     = cur_reg;
        tx_next      = tx_reg;
        ty_next      = ty_reg;
        nx_next      = nx_reg;
        ny_next      = ny_reg;
        j_next       = j_reg;
        ins_next     = ins_reg;
        pend_next    = pend_reg;
        same_next    = same_reg;
        child_next   = child_reg;
        init_next    = init_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            cnt_next[i] = cnt_reg[i];
        end

        fm_we = 1'b0;
        fm_wa = '0;
        fm_wd = {ty_reg, tx_reg};
        fm_ra = {cur_reg, j_reg[IDXW-1:0]};
        sm_we = 1'b0;
        sm_wa = id32[SAW-1:0];
        sm_wd = {1'b1, req_lvl_reg, ty_reg, tx_reg, in_reg.light_hash, in_reg.geometry_hash};
        sm_ra = id32[SAW-1:0];

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                // clear slot valid bits, load top tiles row-major
                if (init32 < 32'(LIGHT_SLOTS)) begin
                    sm_we = 1'b1;
                    sm_wa = init32[SAW-1:0];
                    sm_wd = '0;
                end
                if (init32 < 32'(N0)) begin
                    fm_we = 1'b1;
                    fm_wa = {LW'(0), init32[IDXW-1:0]};
                    fm_wd = {YW'((init32 >> NX0_LOG2) << TOP_U_LOG2),
                             XW'((init32 & 32'(NX0 - 1)) << TOP_U_LOG2)};
                end
                init_next = init_reg + INW'(1);
                if (init32 == 32'(INIT_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    in_next      = s_data;
                    s_sat_next   = s_in;
                    req_lvl_next = LW'(4'(LOG2_MAX) - s_in);
                    state_next   = ST_SLOT_RD;
                end
            end

            ST_SLOT_RD: begin
                res_next.tile_x       = '0;
                res_next.tile_y       = '0;
                res_next.tile_log2    = s_sat_reg;
                res_next.render_mode  = MODE_RENDER;
                res_next.alloc_failed = 1'b1;
                if (id32 >= 32'(LIGHT_SLOTS)) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SLOT_CHK;
                end
            end

            ST_SLOT_CHK: begin
                if (sv && sl == req_lvl_reg) begin
                    // same size: hash check, store new hashes
                    sm_we = 1'b1;
                    sm_wd = {1'b1, sl, sy, sx, in_reg.light_hash, in_reg.geometry_hash};
                    res_next.tile_x       = 12'(32'(sx) << LOG2_MIN);
                    res_next.tile_y       = 12'(32'(sy) << LOG2_MIN);
                    res_next.alloc_failed = 1'b0;
                    if (slh != in_reg.light_hash) begin
                        res_next.render_mode = MODE_RENDER;
                    end else if (sgh != in_reg.geometry_hash) begin
                        res_next.render_mode = MODE_STATIC;
                    end else begin
                        res_next.render_mode = MODE_CACHED;
                    end
                    state_next = ST_FIN;
                end else if (sv) begin
                    cur_next   = sl;
                    tx_next    = sx;
                    ty_next    = sy;
                    state_next = ST_F_START;
                end else begin
                    cur_next   = req_lvl_reg;
                    state_next = ST_A_FIND;
                end
            end

            // ---------------- free path ----------------
            ST_F_START: begin
                if (cur_reg == '0 || c_cur == '0) begin
                    if (c_cur < CW'(LEVEL_CAP)) begin
                        fm_we             = 1'b1;
                        fm_wa             = {cur_reg, c_cur[IDXW-1:0]};
                        cnt_next[cur_reg] = c_cur + CW'(1);
                    end
                    cur_next   = req_lvl_reg;
                    state_next = ST_A_FIND;
                end else begin
                    j_next     = '0;
                    pend_next  = 1'b0;
                    same_next  = '0;
                    state_next = ST_F_SCAN;
                end
            end

            ST_F_SCAN: begin
                // read entry j, compare entry j-1 from the registered read
                fm_ra = {cur_reg, j_reg[IDXW-1:0]};
                if (pend_reg && key_q > key_t) begin
                    ins_next   = j_reg - CW'(1);
                    state_next = ST_F_DEC;
                end else begin
                    if (pend_reg && key_q == key_t && same_reg != 2'd3) begin
                        same_next = same_reg + 2'd1;
                    end
                    if (j_reg < c_cur) begin
                        j_next    = j_reg + CW'(1);
                        pend_next = 1'b1;
                    end else begin
                        ins_next   = c_cur;
                        state_next = ST_F_DEC;
                    end
                end
            end

            ST_F_DEC: begin
                pend_next = 1'b0;
                if (same_reg == 2'd3 && ins_reg >= CW'(3)) begin
                    j_next     = ins_reg;
                    state_next = ST_F_DN;
                end else if (c_cur < CW'(LEVEL_CAP)) begin
                    j_next     = c_cur;
                    state_next = ST_F_UP;
                end else begin
                    cur_next   = req_lvl_reg;
                    state_next = ST_A_FIND;
                end
            end

            ST_F_DN: begin
                // drop three siblings: list[k] -> list[k-3]
                fm_ra = {cur_reg, j_reg[IDXW-1:0]};
                if (pend_reg) begin
                    fm_we = 1'b1;
                    fm_wa = {cur_reg, IDXW'(j_reg - CW'(4))};
                    fm_wd = fm_q;
                end
                if (j_reg < c_cur) begin
                    j_next    = j_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    cnt_next[cur_reg] = c_cur - CW'(3);
                    tx_next    = (tx_reg >> su) << su;
                    ty_next    = (ty_reg >> su) << su;
                    cur_next   = cur_reg - LW'(1);
                    state_next = ST_F_START;
                end
            end

            ST_F_UP: begin
                // open a gap at ins: list[k] -> list[k+1], descending
                fm_ra = {cur_reg, IDXW'(j_reg - CW'(1))};
                if (pend_reg) begin
                    fm_we = 1'b1;
                    fm_wa = {cur_reg, IDXW'(j_reg + CW'(1))};
                    fm_wd = fm_q;
                end
                if (j_reg > ins_reg) begin
                    j_next    = j_reg - CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_F_PUT;
                end
            end

            ST_F_PUT: begin
                fm_we             = 1'b1;
                fm_wa             = {cur_reg, ins_reg[IDXW-1:0]};
                cnt_next[cur_reg] = c_cur + CW'(1);
                cur_next          = req_lvl_reg;
                state_next        = ST_A_FIND;
            end

            // ---------------- allocate path ----------------
            ST_A_FIND: begin
                if (c_cur != '0) begin
                    if (cur_reg == req_lvl_reg) begin
                        state_next = ST_A_LAST;
                    end else begin
                        state_next = ST_A_POP;
                    end
                end else if (cur_reg == '0) begin
                    sm_we = 1'b1;
                    sm_wd = '0;
                    res_next.tile_x       = '0;
                    res_next.tile_y       = '0;
                    res_next.tile_log2    = s_sat_reg;
                    res_next.render_mode  = MODE_RENDER;
                    res_next.alloc_failed = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    cur_next = cur_reg - LW'(1);
                end
            end

            ST_A_POP: begin
                fm_ra             = {cur_reg, IDXW'(c_cur - CW'(1))};
                cnt_next[cur_reg] = c_cur - CW'(1);
                state_next        = ST_A_POPW;
            end

            ST_A_POPW: begin
                nx_next    = qx;
                ny_next    = qy;
                child_next = '0;
                state_next = ST_A_SPLIT;
            end

            ST_A_SPLIT: begin
                // children TL, TR, BL, BR pushed one a cycle
                fm_wd = {child_reg[1] ? ny_reg + YW'(h_u) : ny_reg,
                         child_reg[0] ? nx_reg + h_u : nx_reg};
                if (cnt_reg[lvl_up] < CW'(LEVEL_CAP)) begin
                    fm_we            = 1'b1;
                    fm_wa            = {lvl_up, cnt_reg[lvl_up][IDXW-1:0]};
                    cnt_next[lvl_up] = cnt_reg[lvl_up] + CW'(1);
                end
                child_next = child_reg + 2'd1;
                if (child_reg == 2'd3) begin
                    cur_next = lvl_up;
                    if (lvl_up == req_lvl_reg) begin
                        state_next = ST_A_LAST;
                    end else begin
                        state_next = ST_A_POP;
                    end
                end
            end

            ST_A_LAST: begin
                fm_ra             = {cur_reg, IDXW'(c_cur - CW'(1))};
                cnt_next[cur_reg] = c_cur - CW'(1);
                state_next        = ST_A_LASTW;
            end

            ST_A_LASTW: begin
                sm_we = 1'b1;
                sm_wd = {1'b1, req_lvl_reg, qy, qx, in_reg.light_hash, in_reg.geometry_hash};
                res_next.tile_x       = 12'(32'(qx) << LOG2_MIN);
                res_next.tile_y       = 12'(32'(qy) << LOG2_MIN);
                res_next.tile_log2    = s_sat_reg;
                res_next.render_mode  = MODE_RENDER;
                res_next.alloc_failed = 1'b0;
                state_next = ST_FIN;
            end

            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### sim/atlas_quadtree_buddy_allocator_tb.sv
`timescale 1ns / 1ps

module atlas_quadtree_buddy_allocator_tb;
    import qtba_pkg::*;

    localparam int LOG2_MAX = 11;
    localparam int LOG2_MIN = 7;
    localparam int NLEV     = LOG2_MAX - LOG2_MIN + 1;
    localparam int LCAP     = (4096 / 128) * (4096 / 128);
    localparam int NSLOT    = 64;
    localparam int N_RANDOM = 560;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    qtba_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    qtba_out_t m_data;

    atlas_quadtree_buddy_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor state: per-level free lists of tile corners, slot table
    // ---------------------------------------------------------------
    logic [11:0] fx [NLEV][LCAP];
    logic [11:0] fy [NLEV][LCAP];
    int          fcnt [NLEV];
    logic        sv [NSLOT];
    logic [11:0] stx [NSLOT];
    logic [11:0] sty [NSLOT];
    int          slev [NSLOT];
    logic [63:0] slh [NSLOT];
    logic [63:0] sgh [NSLOT];

    qtba_in_t  pending_reqs[$];
    qtba_out_t expected_tiles[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_failed_allocs = 0;
    int n_cached = 0;

    function automatic void add_req(qtba_in_t rq);
        pending_reqs.insert(pending_reqs.size(), rq);
    endfunction

    task automatic atlas_reset();
        for (int l = 0; l < NLEV; l++) fcnt[l] = 0;
        for (int i = 0; i < NSLOT; i++) begin
            sv[i] = 0; stx[i] = '0; sty[i] = '0; slev[i] = 0; slh[i] = '0; sgh[i] = '0;
        end
        // top level holds the four whole 2048 tiles, row-major
        for (int y = 0; y < 2; y++) begin
            for (int x = 0; x < 2; x++) begin
                fx[0][fcnt[0]] = 12'(x * 2048);
                fy[0][fcnt[0]] = 12'(y * 2048);
                fcnt[0]++;
            end
        end
    endtask

    function automatic void list_push(int l, logic [11:0] x, logic [11:0] y);
        if (fcnt[l] < LCAP) begin
            fx[l][fcnt[l]] = x; fy[l][fcnt[l]] = y; fcnt[l]++;
        end
    endfunction

    // Split down from the nearest non-empty level, this one or coarser, then pop the last node.
    function automatic void carve_tile(int lev, output bit ok, output logic [11:0] ox,
                                       output logic [11:0] oy);
        int k;
        int h;
        logic [11:0] nx, ny;
        k = lev;
        while (k >= 0 && fcnt[k] == 0) k--;
        ok = (k >= 0);
        ox = '0; oy = '0;
        if (ok) begin
            for (int i = k; i < lev; i++) begin
                fcnt[i]--;
                nx = fx[i][fcnt[i]]; ny = fy[i][fcnt[i]];
                h = 1 << (LOG2_MAX - i - 1);
                list_push(i + 1, nx, ny);
                list_push(i + 1, nx + 12'(h), ny);
                list_push(i + 1, nx, ny + 12'(h));
                list_push(i + 1, nx + 12'(h), ny + 12'(h));
            end
            fcnt[lev]--;
            ox = fx[lev][fcnt[lev]]; oy = fy[lev][fcnt[lev]];
        end
    endfunction

    // Ordered insert by parent index; three waiting siblings merge upward.
    function automatic void release_tile(int lev, logic [11:0] x, logic [11:0] y);
        int cnt, sh, pw, pidx, same, ins, pi;
        bit done;
        done = 0;
        while (!done) begin
            if (lev <= 0 || fcnt[lev] == 0) begin
                list_push(lev < 0 ? 0 : lev, x, y);
                done = 1;
            end else begin
                cnt = fcnt[lev];
                sh = LOG2_MAX - lev + 1;
                pw = 4096 >> sh;
                pidx = (int'(y) >> sh) * pw + (int'(x) >> sh);
                same = 0; ins = cnt;
                for (int j = 0; j < cnt; j++) begin
                    pi = (int'(fy[lev][j]) >> sh) * pw + (int'(fx[lev][j]) >> sh);
                    if (pi == pidx) same++;
                    else if (pi > pidx) begin
                        ins = j;
                        break;
                    end
                end
                if (same >= 3 && ins >= 3) begin
                    for (int j = ins; j < cnt; j++) begin
                        fx[lev][j - 3] = fx[lev][j]; fy[lev][j - 3] = fy[lev][j];
                    end
                    fcnt[lev] = cnt - 3;
                    x = 12'((int'(x) >> sh) << sh);
                    y = 12'((int'(y) >> sh) << sh);
                    lev--;
                end else begin
                    if (cnt < LCAP) begin
                        for (int j = cnt; j > ins; j--) begin
                            fx[lev][j] = fx[lev][j - 1]; fy[lev][j] = fy[lev][j - 1];
                        end
                        fx[lev][ins] = x; fy[lev][ins] = y;
                        fcnt[lev] = cnt + 1;
                    end
                    done = 1;
                end
            end
        end
    endfunction

    function automatic qtba_out_t predict_tile(qtba_in_t rq);
        qtba_out_t r;
        int s, lev, id;
        bit ok;
        logic [11:0] tx, ty;
        qtba_mode_t md;
        s = int'(rq.size_log2);
        if (s < LOG2_MIN) s = LOG2_MIN;
        if (s > LOG2_MAX) s = LOG2_MAX;
        lev = LOG2_MAX - s;
        id = int'(rq.light_id);
        r = '0;
        r.tile_log2 = 4'(s);
        if (id >= NSLOT) begin
            r.alloc_failed = 1'b1;
            return r;
        end
        if (!sv[id] || slev[id] != lev) begin
            if (sv[id]) begin
                release_tile(slev[id], stx[id], sty[id]);
                sv[id] = 0;
            end
            carve_tile(lev, ok, tx, ty);
            if (!ok) begin
                r.alloc_failed = 1'b1;
                return r;
            end
            sv[id] = 1; stx[id] = tx; sty[id] = ty; slev[id] = lev;
            md = MODE_RENDER;
        end else if (slh[id] != rq.light_hash) md = MODE_RENDER;
        else if (sgh[id] != rq.geometry_hash) md = MODE_STATIC;
        else md = MODE_CACHED;
        slh[id] = rq.light_hash;
        sgh[id] = rq.geometry_hash;
        r.tile_x = stx[id];
        r.tile_y = sty[id];
        r.tile_log2 = 4'(LOG2_MAX - slev[id]);
        r.render_mode = md;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH beat %0d %s: got %0d expected %0d", n_checked, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Driver: bursts of beats separated by random gaps
    // ---------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_tiles.insert(expected_tiles.size(), predict_tile(s_data));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: receiver stall pattern plus field-by-field check
    // ---------------------------------------------------------------
    int stall_phase = 0;

    always @(posedge aclk) begin
        qtba_out_t want;
        if (aresetn) begin
            // alternate stretches of free flow with randomly stalled stretches
            stall_phase <= (stall_phase + 1) % 400;
            m_ready <= (stall_phase < 150) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (m_valid && m_ready) begin
                if (expected_tiles.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = expected_tiles.pop_front();
                    if (m_data.alloc_failed != want.alloc_failed)
                        report_mismatch("alloc_failed", m_data.alloc_failed, want.alloc_failed);
                    if (m_data.tile_x != want.tile_x)
                        report_mismatch("tile_x", m_data.tile_x, want.tile_x);
                    if (m_data.tile_y != want.tile_y)
                        report_mismatch("tile_y", m_data.tile_y, want.tile_y);
                    if (m_data.tile_log2 != want.tile_log2)
                        report_mismatch("tile_log2", m_data.tile_log2, want.tile_log2);
                    if (m_data.render_mode != want.render_mode)
                        report_mismatch("render_mode", m_data.render_mode, want.render_mode);
                    if (want.alloc_failed) n_failed_allocs++;
                    if (want.render_mode == MODE_CACHED) n_cached++;
                    n_checked++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic qtba_in_t mk_req(int id, logic [63:0] lh, logic [63:0] gh, int sz);
        qtba_in_t q;
        q.light_id = 6'(id);
        q.light_hash = lh;
        q.geometry_hash = gh;
        q.size_log2 = 4'(sz);
        return q;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        logic [63:0] lh [NSLOT];
        logic [63:0] gh [NSLOT];
        int szs [NSLOT];
        int id, r, n_active;
        atlas_reset();

        // directed: saturation, hash outcomes, exhaustion, resize, merge back
        add_req(mk_req(0, '0, '0, 0));              // size below range, saturates to 128
        add_req(mk_req(0, '0, '0, 7));              // same size once saturated: cached
        add_req(mk_req(0, '0, '0, 7));              // cached
        add_req(mk_req(0, '0, '1, 7));              // geometry changed
        add_req(mk_req(0, '1, '1, 7));              // light changed
        add_req(mk_req(63, '1, '1, 15));            // size above range
        add_req(mk_req(62, '1, '0, 11));
        add_req(mk_req(61, 64'h5555, '0, 11));
        add_req(mk_req(60, '0, '0, 11));            // atlas full: fails
        add_req(mk_req(59, '0, '0, 7));             // a spare 128 is still free: allocates
        add_req(mk_req(61, '0, '0, 10));            // resize: frees a 2048, takes a spare 1024
        add_req(mk_req(60, '0, '0, 9));
        add_req(mk_req(59, '0, '0, 8));
        add_req(mk_req(0, '0, '0, 11));             // freed 128 merges into a 256; gets a 2048
        add_req(mk_req(63, '0, '0, 7));             // resize, no merge yet
        add_req(mk_req(61, '0, '0, 7));
        add_req(mk_req(60, '0, '0, 7));
        add_req(mk_req(59, '0, '0, 7));
        add_req(mk_req(62, '0, '0, 7));
        add_req(mk_req(1, '0, '0, 11));
        add_req(mk_req(2, '1, '1, 11));

        // random: a pool of lights re-requesting with mostly stable hashes, so cached,
        // static, resize and free-with-merge paths all get hit; pool size varies
        for (int i = 0; i < NSLOT; i++) begin
            lh[i] = rand64(); gh[i] = rand64(); szs[i] = $urandom_range(7, 11);
        end
        n_active = 8;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 70 == 0) n_active = $urandom_range(4, 64);
            id = $urandom_range(0, n_active - 1);
            r = $urandom_range(0, 99);
            if (r < 8) szs[id] = $urandom_range(0, 15);
            else if (r < 25) szs[id] = ($urandom_range(0, 3) == 0) ? 11 : $urandom_range(7, 10);
            else if (r < 40) lh[id] = rand64();
            else if (r < 55) gh[id] = rand64();
            add_req(mk_req(id, lh[id], gh[id], szs[id]));
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_tiles.size() == 0);
        repeat (200) @(posedge aclk);
        $display("Ran %0d requests, checked %0d results (%0d failed allocations, %0d cached)",
                 n_sent, n_checked, n_failed_allocs, n_cached);
        if (errors == 0 && expected_tiles.size() == 0) begin
            $display("atlas_quadtree_buddy_allocator test passed");
        end else begin
            $display("atlas_quadtree_buddy_allocator test failed");
        end
        $finish;
    end

    // timeout for ~600 beats at their worst case, plus stalls
    initial begin
        #20ms;
        $display("atlas_quadtree_buddy_allocator test failed");
        $finish;
    end

endmodule
